// File: sv/datetime_validate_bcd_pack_unit_defines.svh
// assertion macros shared by the datetime bcd pack rtl
`ifndef DATETIME_VALIDATE_BCD_PACK_UNIT_DEFINES_SVH
`define DATETIME_VALIDATE_BCD_PACK_UNIT_DEFINES_SVH

// same-cycle implication, disabled during reset
`define DVBP_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, disabled during reset
`define DVBP_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: sv/dvbp_pkg.sv
// package: types, constants and small conversion functions for the datetime bcd pack
`timescale 1ns / 1ps
package dvbp_pkg;

  localparam int IN_TDATA_W  = 48;
  localparam int OUT_TDATA_W = 48;

  localparam logic [11:0] YEAR_MIN = 12'd2000;
  localparam logic [11:0] YEAR_MAX = 12'd2099;
  localparam logic [2:0]  WDAY_MAX = 3'd6;
  localparam logic [4:0]  HOUR_MAX = 5'd23;
  localparam logic [5:0]  MINSEC_MAX = 6'd59;

  localparam logic [3:0] MON_JAN = 4'd1;
  localparam logic [3:0] MON_FEB = 4'd2;
  localparam logic [3:0] MON_MAR = 4'd3;
  localparam logic [3:0] MON_APR = 4'd4;
  localparam logic [3:0] MON_MAY = 4'd5;
  localparam logic [3:0] MON_JUN = 4'd6;
  localparam logic [3:0] MON_JUL = 4'd7;
  localparam logic [3:0] MON_AUG = 4'd8;
  localparam logic [3:0] MON_SEP = 4'd9;
  localparam logic [3:0] MON_OCT = 4'd10;
  localparam logic [3:0] MON_NOV = 4'd11;
  localparam logic [3:0] MON_DEC = 4'd12;

  typedef struct packed {
    logic [11:0] year;
    logic [3:0]  month;
    logic [4:0]  day;
    logic [2:0]  weekday_in;
    logic [4:0]  hour;
    logic [5:0]  minute;
    logic [5:0]  second;
  } dvbp_item_t;

  typedef struct packed {
    logic [6:0] second_bcd;
    logic [6:0] minute_bcd;
    logic [5:0] hour_bcd;
    logic [5:0] day_bcd;
    logic [2:0] weekday_out;
    logic [4:0] month_bcd;
    logic [7:0] year_bcd;
  } dvbp_result_t;

  // two-digit bcd, exact for values below 179 (tens by reciprocal 103/1024)
  function automatic logic [7:0] to_bcd(input logic [6:0] v);
    logic [13:0] prod;
    logic [3:0]  tens;
    logic [6:0]  tens_x10;
    logic [6:0]  ones;
    prod     = {7'd0, v} * 14'd103;
    tens     = prod[13:10];
    tens_x10 = {tens[3:0], 3'b000} + {2'b00, tens[3:0], 1'b0};
    ones     = v - tens_x10;
    return {tens, ones[3:0]};
  endfunction

  // days in month, zero for a month code that means nothing
  function automatic logic [4:0] month_len(input logic [3:0] m, input logic leap);
    logic [4:0] len;
    case (m) inside
      MON_FEB:                          len = leap ? 5'd29 : 5'd28;
      MON_APR, MON_JUN, MON_SEP, MON_NOV: len = 5'd30;
      MON_JAN, MON_MAR, MON_MAY, MON_JUL,
      MON_AUG, MON_OCT, MON_DEC:        len = 5'd31;
      default:                          len = 5'd0;
    endcase
    return len;
  endfunction

  // floor(13 * (m' + 1) / 5), january and february taken as months 13 and 14
  function automatic logic [5:0] zeller_month_term(input logic [3:0] m);
    logic [5:0] t;
    case (m)
      MON_JAN: t = 6'd36;
      MON_FEB: t = 6'd39;
      MON_MAR: t = 6'd10;
      MON_APR: t = 6'd13;
      MON_MAY: t = 6'd15;
      MON_JUN: t = 6'd18;
      MON_JUL: t = 6'd20;
      MON_AUG: t = 6'd23;
      MON_SEP: t = 6'd26;
      MON_OCT: t = 6'd28;
      MON_NOV: t = 6'd31;
      MON_DEC: t = 6'd33;
      default: t = 6'd0;
    endcase
    return t;
  endfunction

  // modulo 7 by folding octal digits, since 8 is 1 mod 7
  function automatic logic [2:0] mod7(input logic [7:0] v);
    logic [4:0] s1;
    logic [3:0] s2;
    logic [3:0] r;
    s1 = {2'b00, v[2:0]} + {2'b00, v[5:3]} + {3'b000, v[7:6]};
    s2 = {1'b0, s1[2:0]} + {2'b00, s1[4:3]};
    r  = (s2 >= 4'd7) ? (s2 - 4'd7) : s2;
    return r[2:0];
  endfunction

endpackage

// File: sv/dvbp_check.sv
// field range and calendar checks for one date/time request
`timescale 1ns / 1ps
module dvbp_check (
  input  dvbp_pkg::dvbp_item_t item,
  output logic                 ok
);
  import dvbp_pkg::*;

  logic [11:0] yoff;
  logic        leap;
  logic        year_ok;
  logic        day_ok;

  // within 2000..2099 a year is leap exactly when divisible by 4 (2000 is by 400)
  assign yoff    = item.year - YEAR_MIN;
  assign leap    = (yoff[1:0] == 2'b00);
  assign year_ok = (item.year >= YEAR_MIN) && (item.year <= YEAR_MAX);
  assign day_ok  = (item.day != 5'd0) && (item.day <= month_len(item.month, leap));

  assign ok = year_ok && day_ok &&
              (item.weekday_in <= WDAY_MAX) && (item.hour <= HOUR_MAX) &&
              (item.minute <= MINSEC_MAX) && (item.second <= MINSEC_MAX);

endmodule

// File: sv/dvbp_conv.sv
// bcd packing and weekday calculation for one checked request
`timescale 1ns / 1ps
module dvbp_conv (
  input  dvbp_pkg::dvbp_item_t   item,
  input  logic                   ok,
  output dvbp_pkg::dvbp_result_t res
);
  import dvbp_pkg::*;

  logic [11:0] yoff;
  logic [6:0]  yy;
  logic        early;
  logic        prev_cent;
  logic [6:0]  k;
  logic [7:0]  wsum;
  logic [7:0]  sec_b;
  logic [7:0]  min_b;
  logic [7:0]  hour_b;
  logic [7:0]  day_b;
  logic [7:0]  mon_b;
  logic [7:0]  year_b;

  assign yoff  = item.year - YEAR_MIN;
  assign yy    = yoff[6:0];
  assign early = (item.month == MON_JAN) || (item.month == MON_FEB);
  // january/february of 2000 fall back to 1999: century 19, year of century 99
  assign prev_cent = early && (yy == 7'd0);
  assign k = prev_cent ? 7'd99 : (yy - {6'd0, early});

  // century term j/4 + 5j is 0 mod 7 for 20 and 1 mod 7 for 19;
  // the +6 maps zeller's saturday-first count to sunday = 0
  assign wsum = {3'b000, item.day} + {2'b00, zeller_month_term(item.month)} +
                {1'b0, k} + {3'b000, k[6:2]} + {7'd0, prev_cent} + 8'd6;

  assign sec_b  = to_bcd({1'b0, item.second});
  assign min_b  = to_bcd({1'b0, item.minute});
  assign hour_b = to_bcd({2'b00, item.hour});
  assign day_b  = to_bcd({2'b00, item.day});
  assign mon_b  = to_bcd({3'b000, item.month});
  assign year_b = to_bcd(yy);

  always_comb begin
    res = '0;
    if (ok) begin
      res.second_bcd  = sec_b[6:0];
      res.minute_bcd  = min_b[6:0];
      res.hour_bcd    = hour_b[5:0];
      res.day_bcd     = day_b[5:0];
      res.weekday_out = mod7(wsum);
      res.month_bcd   = mon_b[4:0];
      res.year_bcd    = year_b;
    end
  end

endmodule

// File: sv/datetime_validate_bcd_pack_unit.sv
// top level: date/time check and bcd clock register pack with stream handshakes
//
// usage
//   in_*  : one request per date/time, fields packed in in_tdata (see port comment)
//   out_* : one result per request; out_tuser carries the valid flag, out_tdata the
//           seven bcd clock bytes, all zero when any check failed
//   path: an accepted request is held in the input register, then in the result
//         register, with the checks and conversions in between
//   throughput: one request per cycle while out_tready is high, set by the single
//               combinational pass between the two registers; no iterative unit is involved
//   the weekday byte is recomputed from the date, the input weekday is only
//   range-checked
//   reset (rst_n low, synchronous): both stages are emptied, out_tvalid drops,
//   in_tready comes up on the next cycle
//   receiver stall: the result register holds; the input register still takes a
//   request while it is empty, then in_tready drops until out_tready returns
`timescale 1ns / 1ps
`include "datetime_validate_bcd_pack_unit_defines.svh"
module datetime_validate_bcd_pack_unit (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_tvalid,
  output logic                                in_tready,
  // year[11:0] month[15:12] day[20:16] weekday_in[23:21] hour[28:24]
  // minute[34:29] second[40:35], zero fill above
  input  logic [dvbp_pkg::IN_TDATA_W-1:0]     in_tdata,
  output logic                                out_tvalid,
  input  logic                                out_tready,
  // second_bcd[6:0] minute_bcd[13:7] hour_bcd[19:14] day_bcd[25:20]
  // weekday_out[28:26] month_bcd[33:29] year_bcd[41:34], zero fill above
  output logic [dvbp_pkg::OUT_TDATA_W-1:0]    out_tdata,
  // valid_res[0]
  output logic [0:0]                          out_tuser
);
  import dvbp_pkg::*;

  // input stage
  logic       s1_v_r, s1_v_nxt;
  dvbp_item_t s1_item_r, s1_item_nxt;
  // result stage
  logic                   out_v_r, out_v_nxt;
  logic [OUT_TDATA_W-1:0] out_data_r, out_data_nxt;
  logic                   out_ok_r, out_ok_nxt;

  logic         out_adv;
  logic         in_fire;
  logic         ok;
  dvbp_result_t res;

  // result register frees when empty or being taken this cycle
  assign out_adv   = !out_v_r || out_tready;
  // input register frees when empty or moving into the result register
  assign in_tready = !s1_v_r || out_adv;
  assign in_fire   = in_tvalid && in_tready;

  dvbp_check u_check (
    .item (s1_item_r),
    .ok   (ok)
  );

  dvbp_conv u_conv (
    .item (s1_item_r),
    .ok   (ok),
    .res  (res)
  );

  always_comb begin
    s1_v_nxt    = s1_v_r;
    s1_item_nxt = s1_item_r;
    if (in_tready) begin
      s1_v_nxt = in_tvalid;
    end
    if (in_fire) begin
      s1_item_nxt.year       = in_tdata[11:0];
      s1_item_nxt.month      = in_tdata[15:12];
      s1_item_nxt.day        = in_tdata[20:16];
      s1_item_nxt.weekday_in = in_tdata[23:21];
      s1_item_nxt.hour       = in_tdata[28:24];
      s1_item_nxt.minute     = in_tdata[34:29];
      s1_item_nxt.second     = in_tdata[40:35];
    end
  end

  always_comb begin
    out_v_nxt    = out_v_r;
    out_data_nxt = out_data_r;
    out_ok_nxt   = out_ok_r;
    if (out_adv) begin
      out_v_nxt = s1_v_r;
    end
    if (out_adv && s1_v_r) begin
      out_ok_nxt   = ok;
      out_data_nxt = {6'd0, res.year_bcd, res.month_bcd, res.weekday_out,
                      res.day_bcd, res.hour_bcd, res.minute_bcd, res.second_bcd};
    end
  end

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r  <= 1'b0;
      out_v_r <= 1'b0;
    end else begin
      s1_v_r  <= s1_v_nxt;
      out_v_r <= out_v_nxt;
    end
  end

  // payload, no reset
  always_ff @(posedge clk) begin
    s1_item_r  <= s1_item_nxt;
    out_data_r <= out_data_nxt;
    out_ok_r   <= out_ok_nxt;
  end

  assign out_tvalid   = out_v_r;
  assign out_tdata    = out_data_r;
  assign out_tuser[0] = out_ok_r;

  // a failed check must clear every byte
  `DVBP_ASSERT_NOW(a_invalid_zero, clk, rst_n, out_v_r && !out_ok_r,
                   out_data_r == '0, "invalid result carries nonzero bytes")
  // computed weekday stays within sunday..saturday
  `DVBP_ASSERT_NOW(a_wday_range, clk, rst_n, out_v_r && out_ok_r,
                   out_data_r[28:26] <= WDAY_MAX, "weekday out of range")
  // year byte holds two decimal digits
  `DVBP_ASSERT_NOW(a_year_digits, clk, rst_n, out_v_r && out_ok_r,
                   (out_data_r[37:34] <= 4'd9) && (out_data_r[41:38] <= 4'd9),
                   "year byte is not bcd")
  // a held input stage keeps its request while the result stage is blocked
  `DVBP_ASSERT_NEXT(a_s1_hold, clk, rst_n, s1_v_r && !out_adv,
                    s1_v_r && $stable(s1_item_r), "input stage lost a request")

endmodule

// File: tb/sv/datetime_validate_bcd_pack_unit_tb.sv
// testbench for the date/time check and bcd clock register pack, self-checking against a predictor
`timescale 1ns / 1ps
module datetime_validate_bcd_pack_unit_tb;
  import dvbp_pkg::*;

  // weekday codes as the block reports them
  typedef enum logic [2:0] {
    SUNDAY, MONDAY, TUESDAY, WEDNESDAY, THURSDAY, FRIDAY, SATURDAY
  } weekday_e;

  // one date/time request, fields in natural order
  typedef struct packed {
    logic [11:0] year;
    logic [3:0]  month;
    logic [4:0]  day;
    logic [2:0]  weekday_in;
    logic [4:0]  hour;
    logic [5:0]  minute;
    logic [5:0]  second;
  } dt_req_t;

  // the clock register bytes plus the valid flag
  typedef struct packed {
    logic       valid_res;
    logic [6:0] second_bcd;
    logic [6:0] minute_bcd;
    logic [5:0] hour_bcd;
    logic [5:0] day_bcd;
    logic [2:0] weekday_out;
    logic [4:0] month_bcd;
    logic [7:0] year_bcd;
  } rtc_regs_t;

  typedef struct {
    dt_req_t   req;
    bit        typed;   // expected bytes written in the table, else predicted
    rtc_regs_t regs;
  } dir_row_t;

  localparam int CLK_HALF_NS   = 5;
  localparam int TIMEOUT_NS    = 5_000_000;
  localparam int DRAIN_CYCLES  = 8;
  localparam int MAX_REPORTS   = 10;
  localparam int BAD_WEEKDAY   = 7;

  // any failed check gives all-zero bytes
  localparam rtc_regs_t REJECTED = '0;
  // 2000-01-01 00:00:00 was a saturday
  localparam rtc_regs_t FIRST_DAY_REGS = '{valid_res: 1'b1, second_bcd: 7'h00,
    minute_bcd: 7'h00, hour_bcd: 6'h00, day_bcd: 6'h01, weekday_out: SATURDAY,
    month_bcd: 5'h01, year_bcd: 8'h00};
  // 2099-12-31 23:59:59 is a thursday
  localparam rtc_regs_t LAST_SECOND_REGS = '{valid_res: 1'b1, second_bcd: 7'h59,
    minute_bcd: 7'h59, hour_bcd: 6'h23, day_bcd: 6'h31, weekday_out: THURSDAY,
    month_bcd: 5'h12, year_bcd: 8'h99};

  logic                   clk;
  logic                   rst_n;
  logic                   in_tvalid;
  logic                   in_tready;
  logic [IN_TDATA_W-1:0]  in_tdata;
  logic                   out_tvalid;
  logic                   out_tready;
  logic [OUT_TDATA_W-1:0] out_tdata;
  logic [0:0]             out_tuser;

  rtc_regs_t expected_regs_q[$];
  dir_row_t  dir_table[$];
  int        send_gap_pct;
  int        recv_stall_pct;
  int        mismatch_count;
  int        requests_sent;
  int        valid_seen;
  int        rejected_seen;

  datetime_validate_bcd_pack_unit uut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser)
  );

  initial begin
    clk = 1'b0;
    forever #CLK_HALF_NS clk = ~clk;
  end

  // ---------------------------------------------------------------- predictor

  function automatic bit is_leap(int y);
    return ((y % 4 == 0) && (y % 100 != 0)) || (y % 400 == 0);
  endfunction

  // zero for a month code outside january..december
  function automatic int month_day_count(int y, int m);
    int len;
    case (m)
      MON_FEB:                            len = is_leap(y) ? 29 : 28;
      MON_APR, MON_JUN, MON_SEP, MON_NOV: len = 30;
      MON_JAN, MON_MAR, MON_MAY, MON_JUL,
      MON_AUG, MON_OCT, MON_DEC:          len = 31;
      default:                            len = 0;
    endcase
    return len;
  endfunction

  function automatic logic [7:0] packed_bcd(int v);
    return 8'((v / 10) << 4 | (v % 10));
  endfunction

  // zeller's congruence; january and february belong to the previous year
  function automatic logic [2:0] day_of_week(int y, int m, int d);
    int yy;
    int mm;
    int k;
    int j;
    int h;
    yy = y;
    mm = m;
    if (mm < MON_MAR) begin
      mm = mm + 12;
      yy = yy - 1;
    end
    k = yy % 100;
    j = yy / 100;
    h = (d + (13 * (mm + 1)) / 5 + k + k / 4 + j / 4 + 5 * j) % 7;
    // zeller counts from saturday, shift so sunday is zero
    return 3'((h + 6) % 7);
  endfunction

  function automatic rtc_regs_t predict_rtc_regs(dt_req_t r);
    rtc_regs_t regs;
    bit        ok;
    ok = r.year >= YEAR_MIN && r.year <= YEAR_MAX &&
         r.day >= 1 && int'(r.day) <= month_day_count(r.year, r.month) &&
         r.weekday_in <= WDAY_MAX && r.hour <= HOUR_MAX &&
         r.minute <= MINSEC_MAX && r.second <= MINSEC_MAX;
    regs = REJECTED;
    if (ok) begin
      regs.valid_res   = 1'b1;
      regs.second_bcd  = 7'(packed_bcd(r.second));
      regs.minute_bcd  = 7'(packed_bcd(r.minute));
      regs.hour_bcd    = 6'(packed_bcd(r.hour));
      regs.day_bcd     = 6'(packed_bcd(r.day));
      regs.weekday_out = day_of_week(r.year, r.month, r.day);
      regs.month_bcd   = 5'(packed_bcd(r.month));
      regs.year_bcd    = packed_bcd(r.year % 100);
    end
    return regs;
  endfunction

  // ---------------------------------------------------------------- stimulus helpers

  function automatic dir_row_t row(int y, int m, int d, int w, int h, int mi, int s,
                                   bit typed, rtc_regs_t regs);
    dir_row_t r;
    r.req.year       = y[11:0];
    r.req.month      = m[3:0];
    r.req.day        = d[4:0];
    r.req.weekday_in = w[2:0];
    r.req.hour       = h[4:0];
    r.req.minute     = mi[5:0];
    r.req.second     = s[5:0];
    r.typed          = typed;
    r.regs           = regs;
    return r;
  endfunction

  // mostly well-formed dates/times, some with one field broken, some pure noise
  function automatic dt_req_t random_request();
    dt_req_t r;
    int      pick;
    int      len;
    pick = $urandom_range(0, 99);
    r = dt_req_t'({$urandom, $urandom});
    if (pick >= 15) begin
      r.year       = 12'(YEAR_MIN + $urandom_range(0, 99));
      r.month      = 4'($urandom_range(MON_JAN, MON_DEC));
      len          = month_day_count(r.year, r.month);
      // lean on month ends, where the leap and 30/31 rules bite
      r.day        = ($urandom_range(0, 3) == 0) ? 5'(len) : 5'($urandom_range(1, len));
      r.weekday_in = 3'($urandom_range(0, WDAY_MAX));
      r.hour       = 5'($urandom_range(0, HOUR_MAX));
      r.minute     = 6'($urandom_range(0, MINSEC_MAX));
      r.second     = 6'($urandom_range(0, MINSEC_MAX));
      if (pick < 35) begin
        case ($urandom_range(0, 6))
          0: r.year = $urandom_range(0, 1) ? 12'($urandom_range(0, YEAR_MIN - 1))
                                           : 12'($urandom_range(YEAR_MAX + 1, 4095));
          1: r.month = $urandom_range(0, 1) ? 4'd0 : 4'($urandom_range(MON_DEC + 1, 15));
          2: r.day = (len == 31 || $urandom_range(0, 1)) ? 5'd0
                                                         : 5'($urandom_range(len + 1, 31));
          3: r.weekday_in = 3'(BAD_WEEKDAY);
          4: r.hour = 5'($urandom_range(HOUR_MAX + 1, 31));
          5: r.minute = 6'($urandom_range(MINSEC_MAX + 1, 63));
          default: r.second = 6'($urandom_range(MINSEC_MAX + 1, 63));
        endcase
      end
    end
    return r;
  endfunction

  // called at a falling edge, returns at the falling edge after acceptance
  task automatic send_request(dt_req_t r, rtc_regs_t regs);
    while ($urandom_range(0, 99) < send_gap_pct) begin
      in_tvalid <= 1'b0;
      @(negedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= IN_TDATA_W'({r.second, r.minute, r.hour, r.weekday_in,
                              r.day, r.month, r.year});
    do @(posedge clk); while (in_tready !== 1'b1);
    expected_regs_q.push_back(regs);
    requests_sent++;
    @(negedge clk);
  endtask

  // hold the sender off until every outstanding result is back
  task automatic wait_results_drained();
    in_tvalid <= 1'b0;
    while (expected_regs_q.size() != 0) @(posedge clk);
    @(negedge clk);
  endtask

  // ---------------------------------------------------------------- receiver side

  // random back-pressure, changed only at falling edges
  always @(negedge clk) begin
    out_tready <= ($urandom_range(0, 99) >= recv_stall_pct);
  end

  // compare every accepted result with the oldest expectation
  always @(posedge clk) begin
    rtc_regs_t got;
    rtc_regs_t want;
    if (rst_n === 1'b1 && out_tvalid === 1'b1 && out_tready === 1'b1) begin
      got.valid_res   = out_tuser[0];
      got.second_bcd  = out_tdata[6:0];
      got.minute_bcd  = out_tdata[13:7];
      got.hour_bcd    = out_tdata[19:14];
      got.day_bcd     = out_tdata[25:20];
      got.weekday_out = out_tdata[28:26];
      got.month_bcd   = out_tdata[33:29];
      got.year_bcd    = out_tdata[41:34];
      if (expected_regs_q.size() == 0) begin
        mismatch_count++;
        if (mismatch_count <= MAX_REPORTS)
          $display("%0t: result with no request outstanding: %p", $realtime, got);
      end else begin
        want = expected_regs_q.pop_front();
        if (got.valid_res !== want.valid_res || got.second_bcd !== want.second_bcd ||
            got.minute_bcd !== want.minute_bcd || got.hour_bcd !== want.hour_bcd ||
            got.day_bcd !== want.day_bcd || got.weekday_out !== want.weekday_out ||
            got.month_bcd !== want.month_bcd || got.year_bcd !== want.year_bcd) begin
          mismatch_count++;
          if (mismatch_count <= MAX_REPORTS) begin
            $display("%0t: wrong clock bytes", $realtime);
            $display("  expected %p", want);
            $display("  actual   %p", got);
          end
        end
        if (want.valid_res) valid_seen++;
        else rejected_seen++;
      end
    end
  end

  // ---------------------------------------------------------------- run control

  initial begin
    #TIMEOUT_NS;
    $display("datetime_validate_bcd_pack_unit: mismatch");
    $finish;
  end

  initial begin
    int phase_len[4]   = '{160, 160, 160, 150};
    int phase_gap[4]   = '{0, 50, 0, 26};
    int phase_stall[4] = '{0, 0, 50, 26};
    dt_req_t r;

    rst_n          = 1'b0;
    in_tvalid      = 1'b0;
    in_tdata       = '0;
    out_tready     = 1'b0;
    send_gap_pct   = 0;
    recv_stall_pct = 0;
    mismatch_count = 0;
    requests_sent  = 0;
    valid_seen     = 0;
    rejected_seen  = 0;

    // extremes, leap rules, month lengths and each range check on its own
    dir_table.push_back(row(YEAR_MIN, MON_JAN, 1, SATURDAY, 0, 0, 0, 1, FIRST_DAY_REGS));
    dir_table.push_back(row(YEAR_MAX, MON_DEC, 31, SUNDAY, HOUR_MAX, MINSEC_MAX, MINSEC_MAX,
                            1, LAST_SECOND_REGS));
    dir_table.push_back(row(2000, MON_FEB, 29, TUESDAY, 12, 30, 45, 0, REJECTED));
    dir_table.push_back(row(2004, MON_FEB, 29, SUNDAY, 1, 2, 3, 0, REJECTED));
    dir_table.push_back(row(2001, MON_FEB, 28, WEDNESDAY, 10, 10, 10, 0, REJECTED));
    dir_table.push_back(row(2001, MON_FEB, 29, THURSDAY, 10, 10, 10, 1, REJECTED));
    dir_table.push_back(row(2000, MON_FEB, 30, MONDAY, 0, 0, 0, 1, REJECTED));
    dir_table.push_back(row(2000, MON_FEB, 1, TUESDAY, 8, 9, 10, 0, REJECTED));
    dir_table.push_back(row(2000, MON_MAR, 1, WEDNESDAY, 0, 0, 0, 0, REJECTED));
    dir_table.push_back(row(2050, MON_APR, 30, SATURDAY, 19, 45, 0, 0, REJECTED));
    dir_table.push_back(row(2050, MON_APR, 31, SUNDAY, 19, 45, 0, 1, REJECTED));
    dir_table.push_back(row(YEAR_MIN - 1, MON_DEC, 31, FRIDAY, 23, 59, 59, 1, REJECTED));
    dir_table.push_back(row(YEAR_MAX + 1, MON_JAN, 1, FRIDAY, 0, 0, 0, 1, REJECTED));
    dir_table.push_back(row(0, 0, 0, SUNDAY, 0, 0, 0, 1, REJECTED));
    dir_table.push_back(row(4095, 15, 31, BAD_WEEKDAY, 31, 63, 63, 1, REJECTED));
    dir_table.push_back(row(2024, 0, 10, MONDAY, 5, 5, 5, 1, REJECTED));
    dir_table.push_back(row(2024, MON_DEC + 1, 10, MONDAY, 5, 5, 5, 1, REJECTED));
    dir_table.push_back(row(2024, MON_JUN, 0, MONDAY, 5, 5, 5, 1, REJECTED));
    dir_table.push_back(row(2024, MON_JUN, 15, BAD_WEEKDAY, 5, 5, 5, 1, REJECTED));
    dir_table.push_back(row(2024, MON_JUN, 15, SATURDAY, HOUR_MAX + 1, 5, 5, 1, REJECTED));
    dir_table.push_back(row(2024, MON_JUN, 15, SATURDAY, 5, MINSEC_MAX + 1, 5, 1, REJECTED));
    dir_table.push_back(row(2024, MON_JUN, 15, SATURDAY, 5, 5, MINSEC_MAX + 1, 1, REJECTED));
    // input weekday deliberately wrong on the first row, it must not reach the result
    dir_table.push_back(row(2024, MON_JUL, 4, SUNDAY, 16, 20, 0, 0, REJECTED));
    dir_table.push_back(row(2099, MON_NOV, 30, MONDAY, 9, 5, 7, 0, REJECTED));

    repeat (3) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    foreach (dir_table[i])
      send_request(dir_table[i].req,
                   dir_table[i].typed ? dir_table[i].regs
                                      : predict_rtc_regs(dir_table[i].req));
    wait_results_drained();

    // pacing phases: free running, sender gaps, receiver stalls, both
    for (int p = 0; p < 4; p++) begin
      @(posedge clk);
      send_gap_pct   = phase_gap[p];
      recv_stall_pct = phase_stall[p];
      @(negedge clk);
      repeat (phase_len[p]) begin
        r = random_request();
        send_request(r, predict_rtc_regs(r));
      end
      wait_results_drained();
    end

    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("covered %0d requests (%0d from the directed table) over four pacing phases",
             requests_sent, dir_table.size());
    $display("results: %0d packed as clock bytes, %0d rejected, %0d mismatches",
             valid_seen, rejected_seen, mismatch_count);
    if (mismatch_count == 0 && expected_regs_q.size() == 0) begin
      $display("datetime_validate_bcd_pack_unit: match");
    end else begin
      $display("datetime_validate_bcd_pack_unit: mismatch");
    end
    $finish;
  end

endmodule
